@@ rtl/core/integer_to_radix_ascii_core_macros.svh @@
// Assertion macros shared by the integer_to_radix_ascii_core RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IRA_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer_to_radix_ascii_core: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IRA_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer_to_radix_ascii_core: assertion failed");

`endif

@@ rtl/core/ira_pkg.sv @@
// Shared types, constants and character helpers for integer_to_radix_ascii_core.
// Depends on nothing; imported by the divider and the top level.
package ira_pkg;

  localparam int VALUE_W = 64;
  localparam int BASE_W  = 6;
  localparam int CNT_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int DIV_STEP = 8;

  localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
  localparam logic [BASE_W-1:0] BASE_BIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_B       = 8'h62;
  localparam logic [CHAR_W-1:0] CH_O       = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
    logic [CNT_W-1:0]   writable;
  } ira_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic              empty_res;
    logic [CNT_W-1:0]  count;
  } ira_out_t;

  typedef struct packed {
    logic done;
    logic quotient_zero;
  } ira_div_status_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {2'b00, d};
    if (d < 6'd10) begin
      return CH_ZERO + d_ext;
    end else if (d < 6'd36) begin
      return CH_UPPER_A + d_ext - 8'd10;
    end else begin
      return CH_ZERO;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] prefix_char(input logic [BASE_W-1:0] b);
    logic [CHAR_W-1:0] ch;
    unique case (b)
      BASE_BIN: ch = CH_B;
      BASE_OCT: ch = CH_O;
      BASE_HEX: ch = CH_X;
      default:  ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/ira_divider.sv @@
// Iterative divider of a wide unsigned value by a small radix, eight quotient bits a cycle.
// Depends on ira_pkg.
module ira_divider import ira_pkg::*; #(
  parameter int WORK_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORK_BITS-1:0] dividend,
  input  logic [DIGIT_W-1:0]   divisor,
  output ira_div_status_t      status,
  output logic [WORK_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]   remainder
);

  localparam int CYCLES   = WORK_BITS / DIV_STEP;
  localparam int CNT_BITS = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic [WORK_BITS-1:0] work;
  logic [WORK_BITS-1:0] work_next;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   rem_next;
  logic [DIGIT_W-1:0]   divisor_q;
  logic [CNT_BITS-1:0]  cnt;
  logic                 running;
  logic                 done;
  logic [DIV_STEP-1:0]  qbits;

  // Eight restoring steps on the narrow partial remainder, top dividend bits first.
  always_comb begin
    logic [DIGIT_W:0] trial;
    rem_next = rem;
    qbits    = '0;
    for (int j = 0; j < DIV_STEP; j++) begin
      trial = {rem_next, work[WORK_BITS-1-j]};
      if (trial >= {1'b0, divisor_q}) begin
        rem_next = DIGIT_W'(trial - {1'b0, divisor_q});
        qbits[DIV_STEP-1-j] = 1'b1;
      end else begin
        rem_next = trial[DIGIT_W-1:0];
      end
    end
    work_next = (work << DIV_STEP) | WORK_BITS'(qbits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_BITS'(CYCLES - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work      <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
    end else if (running) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign status.done          = done;
  assign status.quotient_zero = (work == '0);
  assign quotient             = work;
  assign remainder            = rem;

endmodule

@@ rtl/core/integer_to_radix_ascii_core.sv @@
// Top level of the integer to radix ASCII converter: sequencer, digit store, emit path.
// Depends on ira_pkg, ira_divider and integer_to_radix_ascii_core_macros.svh.
//
//   Channel   Handshake               Payload    Direction
//   request   start && !busy          ira_in_t   in
//   result    result_strobe (1 cyc)   ira_out_t  out
//
// Each accepted transaction with a valid base and limit is split into digits by one shared
// divider. Each digit takes a division pass plus a turnaround, so an item takes one pass per
// digit and then k character sends from acceptance to its last result, where k is the
// number of characters sent; the worst case is base 2 at 64 bits with a 64-character limit.
// A new request is accepted only once the sequencer is back in idle.
// An invalid base or a zero limit gives its single empty result in the cycle after acceptance.
// Reset is synchronous and returns the sequencer to idle; the digit store is not cleared.
// The receiver cannot stall: characters leave one per cycle, in consecutive cycles.
`include "integer_to_radix_ascii_core_macros.svh"

module integer_to_radix_ascii_core import ira_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  ira_in_t  request,
  output logic     result_strobe,
  output ira_out_t result
);

  // The digit store holds at most one digit per value bit (base 2).
  localparam int DEPTH      = VALUE_BITS;
  localparam int AW         = $clog2(DEPTH);
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int WORK_BITS  = DIV_CYCLES * DIV_STEP;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIVIDE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  // What the registered output stage is showing.
  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_PREFIX = 2'd1;
  localparam logic [1:0] KIND_DIGIT  = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [CNT_W-1:0]     digit_count;
  logic [CNT_W-1:0]     digit_count_next;
  logic [CNT_W-1:0]     emit_index;
  logic [CNT_W-1:0]     emit_index_next;

  // Per-transaction payload latched at acceptance; char_total is latched when division ends.
  logic [BASE_W-1:0]    base_q;
  logic [CNT_W-1:0]     limit_q;
  logic [CHAR_W-1:0]    prefix_q;
  logic [CNT_W-1:0]     char_total;

  logic [DIGIT_W-1:0]   store [DEPTH];
  logic [DIGIT_W-1:0]   rd_data;
  logic [AW-1:0]        rd_addr;
  logic [CNT_W-1:0]     addr_full;
  logic                 store_we;

  logic                 pend_valid;
  logic                 pend_valid_next;
  logic [1:0]           pend_kind;
  logic [1:0]           pend_kind_next;
  logic                 pend_last;
  logic                 pend_last_next;
  logic [CNT_W-1:0]     pend_count;
  logic [CNT_W-1:0]     pend_count_next;

  logic [CNT_W-1:0]     req_limit;
  logic                 req_valid;
  logic                 accept;
  logic [CNT_W-1:0]     prefix_len;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     total;
  logic                 emit_last;
  logic                 latch_total;

  logic                 div_start;
  logic [WORK_BITS-1:0] div_dividend;
  logic [WORK_BITS-1:0] div_quotient;
  logic [DIGIT_W-1:0]   div_remainder;
  ira_div_status_t      div_status;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // The limit is capped at the longest text the block will send.
  assign req_limit = (request.writable > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS)
                                                            : request.writable;
  assign req_valid = (request.base >= MIN_BASE) && (request.base <= MAX_BASE) &&
                     (req_limit != '0);

  assign prefix_len = (prefix_q != CH_NONE) ? CNT_W'(2) : CNT_W'(0);
  assign count_inc  = digit_count + 1'b1;
  assign total      = prefix_len + count_inc;

  // Digits are stored least significant first, so the text reads the store backwards.
  assign addr_full = digit_count - CNT_W'(1) - emit_index + prefix_len;
  assign rd_addr   = addr_full[AW-1:0];
  assign emit_last = ((emit_index + 1'b1) == char_total);

  // The divider restarts on a nonzero quotient in the same cycle that it reports a digit.
  assign store_we     = (state == S_DIVIDE) && div_status.done;
  assign div_start    = (accept && req_valid) || (store_we && !div_status.quotient_zero);
  assign div_dividend = (state == S_IDLE) ? WORK_BITS'(request.value[VALUE_BITS-1:0])
                                          : div_quotient;

  ira_divider #(
    .WORK_BITS (WORK_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base_sel(state, request.base, base_q)),
    .status    (div_status),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  function automatic logic [BASE_W-1:0] base_sel(input logic [1:0] st,
                                                 input logic [BASE_W-1:0] req_base,
                                                 input logic [BASE_W-1:0] held_base);
    return (st == S_IDLE) ? req_base : held_base;
  endfunction

  always_comb begin
    state_next       = state;
    digit_count_next = digit_count;
    emit_index_next  = emit_index;
    pend_valid_next  = 1'b0;
    pend_kind_next   = pend_kind;
    pend_last_next   = 1'b0;
    pend_count_next  = '0;
    latch_total      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_valid) begin
            state_next       = S_DIVIDE;
            digit_count_next = '0;
            emit_index_next  = '0;
          end else begin
            // Empty transaction: one result, nothing else changes but the counters.
            digit_count_next = '0;
            emit_index_next  = '0;
            pend_valid_next  = 1'b1;
            pend_kind_next   = KIND_EMPTY;
            pend_last_next   = 1'b1;
          end
        end
      end
      S_DIVIDE: begin
        if (div_status.done) begin
          digit_count_next = count_inc;
          if (div_status.quotient_zero) begin
            state_next      = S_EMIT;
            emit_index_next = '0;
            latch_total     = 1'b1;
          end
        end
      end
      S_EMIT: begin
        // One character a cycle; the store read lands with the output stage.
        pend_valid_next = 1'b1;
        if (emit_index == '0 && prefix_len != '0) begin
          pend_kind_next = KIND_ZERO;
        end else if (emit_index < prefix_len) begin
          pend_kind_next = KIND_PREFIX;
        end else begin
          pend_kind_next = KIND_DIGIT;
        end
        pend_last_next  = emit_last;
        pend_count_next = emit_last ? char_total : '0;
        emit_index_next = emit_index + 1'b1;
        if (emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      emit_index  <= '0;
      pend_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
      emit_index  <= emit_index_next;
      pend_valid  <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind  <= pend_kind_next;
    pend_last  <= pend_last_next;
    pend_count <= pend_count_next;
    if (accept) begin
      base_q   <= request.base;
      limit_q  <= req_limit;
      prefix_q <= prefix_char(request.base);
    end
    if (latch_total) begin
      char_total <= (total < limit_q) ? total : limit_q;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[digit_count[AW-1:0]] <= div_remainder;
    end
    rd_data <= store[rd_addr];
  end

  assign result_strobe = pend_valid;

  always_comb begin
    result.is_last   = pend_last;
    result.empty_res = (pend_kind == KIND_EMPTY);
    result.count     = pend_count;
    case (pend_kind)
      KIND_ZERO:   result.char_code = CH_ZERO;
      KIND_PREFIX: result.char_code = prefix_q;
      KIND_DIGIT:  result.char_code = digit_glyph(rd_data);
      default:     result.char_code = CH_NONE;
    endcase
  end

  `IRA_NEXT(a_invalid_gives_empty, clk, rst, accept && !req_valid,
            result_strobe && result.empty_res)
  `IRA_IMPL(a_empty_form, clk, rst, result_strobe && result.empty_res,
            result.is_last && result.count == '0 && result.char_code == CH_NONE)
  `IRA_NEXT(a_chars_contiguous, clk, rst, result_strobe && !result.is_last, result_strobe)
  `IRA_IMPL(a_store_in_range, clk, rst, store_we, digit_count < CNT_W'(DEPTH))

endmodule
